// File: rtl/hotp_hmac_sha1_generator_defines.svh
// Assertion macros used by the checker module.
`ifndef HOTP_HMAC_SHA1_GENERATOR_DEFINES_SVH
`define HOTP_HMAC_SHA1_GENERATOR_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define HOTP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define HOTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/hotp_pkg.sv
package hotp_pkg;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned KEY_W = 64;
   localparam int unsigned OTP_W = 20;
   localparam logic [31:0] PAD_IN = 32'h36363636;
   localparam logic [31:0] PAD_OUT = 32'h5c5c5c5c;
   localparam logic [31:0] PAD_BIT = 32'h80000000;
   localparam logic [31:0] LEN_IN = 32'd576;
   localparam logic [31:0] LEN_OUT = 32'd672;
   localparam logic [31:0] OTP_MOD = 32'd1000000;
   // Rounded-up 2^50 / 1000000. The product with any 31-bit value, shifted
   // right by 50, gives the exact quotient by one million.
   localparam logic [31:0] OTP_RECIP = 32'd1125899907;

   localparam logic [1:0] CSR_KEY0 = 2'd0;
   localparam logic [1:0] CSR_KEY1 = 2'd1;
   localparam logic [1:0] CSR_KEY2 = 2'd2;

   typedef logic [31:0] word_type;
   typedef word_type [4:0] digest_type;

   function automatic word_type sha1_k(input logic [6:0] t);
      word_type k;
      if (t < 7'd20) begin
         k = 32'h5a827999;
      end else if (t < 7'd40) begin
         k = 32'h6ed9eba1;
      end else if (t < 7'd60) begin
         k = 32'h8f1bbcdc;
      end else begin
         k = 32'hca62c1d6;
      end
      return k;
   endfunction

   function automatic word_type sha1_f(input logic [6:0] t, input word_type b,
                                       input word_type c, input word_type d);
      word_type f;
      if (t < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (t < 7'd40 || t >= 7'd60) begin
         f = b ^ c ^ d;
      end else begin
         f = (b & c) | (b & d) | (c & d);
      end
      return f;
   endfunction

   function automatic digest_type sha1_iv();
      digest_type h;
      h[0] = 32'h67452301;
      h[1] = 32'hefcdab89;
      h[2] = 32'h98badcfe;
      h[3] = 32'h10325476;
      h[4] = 32'hc3d2e1f0;
      return h;
   endfunction
endpackage

// File: rtl/hotp_hmac_sha1_generator.sv
// An accepted item runs four compressions (schedule load, 80 rounds, chaining fold
// each), then truncation, one reciprocal multiply for the quotient and the remainder
// fix-up at the output. The next item is taken only after the result is written; the
// single SHA-1 round unit runs one round a cycle.
// Reset (synchronous, active high) clears the key registers, the sequencer and
// the result valid flag.
module hotp_hmac_sha1_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] counter
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [19:0] otp_value, [23:20] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import hotp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_TRUNC,
      ST_MOD,
      ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] key0_ff, key0_in;
   logic [63:0] key1_ff, key1_in;
   logic [31:0] key2_ff, key2_in;
   logic [63:0] ctr_ff, ctr_in;
   // Which of the four compressions runs: bit 1 selects the outer hash and
   // bit 0 the second (message) block.
   logic [1:0]  blk_ff, blk_in;
   logic [6:0]  t_ff, t_in;
   digest_type  h_ff, h_in;
   digest_type  hi_ff, hi_in;
   word_type    a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in, e_ff, e_in;
   // Sixteen-word message schedule window, w[0] is the current word.
   word_type    w_ff [16];
   word_type    w_in [16];
   logic [31:0] rem_ff, rem_in;
   logic [11:0] quo_ff, quo_in;
   logic        rv_ff, rv_in;
   logic [19:0] otp_ff, otp_in;

   word_type    blk_word [16];
   word_type    pad;
   word_type    tmp, wnext;
   logic [159:0] dig;
   logic [3:0]  off;
   logic [31:0] sel;
   logic [63:0] prod;
   logic [31:0] quo_back;
   logic [31:0] rem_fix;

   always_comb begin
      pad = blk_ff[1] ? PAD_OUT : PAD_IN;
      for (int i = 0; i < 16; i++) begin
         blk_word[i] = '0;
      end
      if (!blk_ff[0]) begin
         blk_word[0] = key0_ff[63:32] ^ pad;
         blk_word[1] = key0_ff[31:0] ^ pad;
         blk_word[2] = key1_ff[63:32] ^ pad;
         blk_word[3] = key1_ff[31:0] ^ pad;
         blk_word[4] = key2_ff ^ pad;
         for (int i = 5; i < 16; i++) begin
            blk_word[i] = pad;
         end
      end else if (!blk_ff[1]) begin
         blk_word[0] = ctr_ff[63:32];
         blk_word[1] = ctr_ff[31:0];
         blk_word[2] = PAD_BIT;
         blk_word[15] = LEN_IN;
      end else begin
         for (int i = 0; i < 5; i++) begin
            blk_word[i] = hi_ff[i];
         end
         blk_word[5] = PAD_BIT;
         blk_word[15] = LEN_OUT;
      end
   end

   // Shared round unit.
   assign tmp = {a_ff[26:0], a_ff[31:27]} + sha1_f(t_ff, b_ff, c_ff, d_ff) + e_ff
                + sha1_k(t_ff) + w_ff[0];
   assign wnext = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];

   assign dig = {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
   assign off = dig[3:0];
   assign sel = dig[159 - 8 * off -: 32];

   // Modulo one million: the quotient comes from a reciprocal multiply, and the
   // remainder is the value minus the quotient times one million.
   assign prod = rem_ff * OTP_RECIP;
   assign quo_back = {20'd0, quo_ff} * OTP_MOD;
   assign rem_fix = rem_ff - quo_back;

   always_comb begin
      state_in = state_ff;
      key0_in = key0_ff;
      key1_in = key1_ff;
      key2_in = key2_ff;
      ctr_in = ctr_ff;
      blk_in = blk_ff;
      t_in = t_ff;
      h_in = h_ff;
      hi_in = hi_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      w_in = w_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      rv_in = rv_ff;
      otp_in = otp_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_KEY0: key0_in = csr_wdata;
            CSR_KEY1: key1_in = csr_wdata;
            CSR_KEY2: key2_in = csr_wdata[31:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctr_in = req_tdata;
               blk_in = 2'd0;
               h_in = sha1_iv();
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            w_in = blk_word;
            a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2];
            d_in = h_ff[3]; e_in = h_ff[4];
            t_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            e_in = d_ff;
            d_in = c_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            b_in = a_ff;
            a_in = tmp;
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[15] = {wnext[30:0], wnext[31]};
            t_in = t_ff + 7'd1;
            if (t_ff == 7'd79) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            h_in[4] = h_ff[4] + e_ff;
            blk_in = blk_ff + 2'd1;
            state_in = ST_LOAD;
            if (blk_ff == 2'd1) begin
               hi_in[0] = h_ff[0] + a_ff;
               hi_in[1] = h_ff[1] + b_ff;
               hi_in[2] = h_ff[2] + c_ff;
               hi_in[3] = h_ff[3] + d_ff;
               hi_in[4] = h_ff[4] + e_ff;
               h_in = sha1_iv();
            end else if (blk_ff == 2'd3) begin
               state_in = ST_TRUNC;
            end
         end
         ST_TRUNC: begin
            rem_in = {1'b0, sel[30:0]};
            state_in = ST_MOD;
         end
         ST_MOD: begin
            quo_in = prod[61:50];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // The result register is free once the previous result is taken.
            if (!rv_ff || rsp_tready) begin
               otp_in = rem_fix[19:0];
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rv_ff && rsp_tready && state_ff != ST_OUT) begin
         rv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         key0_ff <= '0;
         key1_ff <= '0;
         key2_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         key0_ff <= key0_in;
         key1_ff <= key1_in;
         key2_ff <= key2_in;
         rv_ff <= rv_in;
      end
      ctr_ff <= ctr_in;
      blk_ff <= blk_in;
      t_ff <= t_in;
      h_ff <= h_in;
      hi_ff <= hi_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      w_ff <= w_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      otp_ff <= otp_in;
   end

   // A new item may start while the previous result still waits in the
   // output register; only the final write of the result waits for it.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {4'd0, otp_ff};
endmodule

// File: rtl/hotp_checker.sv
`include "hotp_hmac_sha1_generator_defines.svh"
module hotp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   `HOTP_ASSERT_IMPL(a_range, clock, reset, rsp_tvalid, rsp_tdata < 24'd1000000)
   `HOTP_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata))
   `HOTP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready,
                     !req_tready)
endmodule

bind hotp_hmac_sha1_generator hotp_checker u_hotp_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
